// ===== src/sibm_pkg.sv =====
// ----------------------------------------------------------------------------
// sibm_pkg
// Shared constants, item types and the per-axis sort key for the index map
// builder.
// ----------------------------------------------------------------------------
package sibm_pkg;

    localparam int DEF_MAX_VERTICES = 256;
    localparam int DEF_MAX_LAYERS   = 16;
    localparam int DEF_MAX_TEMPLATE = 1024;
    localparam int AXES             = 3;

    localparam int COORD_W  = 16;
    localparam int VERTEX_W = 3 * COORD_W;
    localparam int SPAN_W   = 9;
    localparam int COUNT_W  = 11;
    localparam int OFFSET_W = 8;
    localparam int INDEX_W  = 8;

    typedef enum logic [1:0] {
        OP_VERTEX   = 2'd0,
        OP_LAYER    = 2'd1,
        OP_TEMPLATE = 2'd2,
        OP_READ     = 2'd3
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic signed [COORD_W-1:0]  coord_x;
        logic signed [COORD_W-1:0]  coord_y;
        logic signed [COORD_W-1:0]  coord_z;
        logic [SPAN_W-1:0]          layer_span;
        logic [COUNT_W-1:0]         layer_entries;
        logic [OFFSET_W-1:0]        template_offset;
    } item_t;

    // head of the front queue as seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } qhead_t;

    // vertex word is {x, y, z}; sign bit flipped so an unsigned compare orders it
    function automatic logic [VERTEX_W-1:0] sort_key(input logic [1:0] axis,
                                                     input logic [VERTEX_W-1:0] v);
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [VERTEX_W-1:0] k;
        x = {~v[47], v[46:32]};
        y = {~v[31], v[30:16]};
        z = {~v[15], v[14:0]};
        case (axis)
            2'd0:    k = {x, z, y};
            2'd1:    k = {y, x, z};
            default: k = {z, y, x};
        endcase
        return k;
    endfunction

endpackage

// ===== src/sibm_if.sv =====
// ----------------------------------------------------------------------------
// sibm_cmd_if / sibm_res_if
// Valid/ready channels for command items and index result items.
// ----------------------------------------------------------------------------
interface sibm_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic [8:0]         layer_span;
    logic [10:0]        layer_entries;
    logic [7:0]         template_offset;

    modport source (output valid, mode, coord_x, coord_y, coord_z, layer_span,
                    layer_entries, template_offset, input ready);
    modport sink (input valid, mode, coord_x, coord_y, coord_z, layer_span,
                  layer_entries, template_offset, output ready);
endinterface

interface sibm_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] index_value;
    logic [1:0] view_axis;
    logic       last_index;
    logic       range_error;

    modport source (output valid, index_value, view_axis, last_index, range_error,
                    input ready);
    modport sink (input valid, index_value, view_axis, last_index, range_error,
                  output ready);
endinterface

// ===== src/axis_sorted_index_map_builder_core.sv =====
// ----------------------------------------------------------------------------
// axis_sorted_index_map_builder_core
// Builds per-axis sorted vertex index lists from loaded vertices, layers and
// template offsets.
// ----------------------------------------------------------------------------
// Items on cmd load a vertex, a layer descriptor or a template offset, or ask
// for the next index. A two-deep queue decouples acceptance from the
// sequencer, so cmd keeps flowing while a result waits in the output
// register. A read steps past used-up layers one descriptor at a time, since
// every layer descriptor comes from a RAM with registered read. The first
// read of each axis also ranks all n loaded vertices through the one vertex
// RAM read port, one compare a cycle. Loads rewind the read walk to axis 0
// and force a fresh sort.
module axis_sorted_index_map_builder_core #(
    parameter int MAX_VERTICES = sibm_pkg::DEF_MAX_VERTICES,
    parameter int MAX_LAYERS   = sibm_pkg::DEF_MAX_LAYERS,
    parameter int MAX_TEMPLATE = sibm_pkg::DEF_MAX_TEMPLATE
) (
    input logic        clk,
    input logic        rst_n,
    sibm_cmd_if.sink   cmd,
    sibm_res_if.source res
);
    import sibm_pkg::*;

    qhead_t head;   // oldest queued item
    logic   pop;    // sequencer takes it

    // front: accept and decode, queue
    sibm_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .head  (head),
        .pop   (pop)
    );

    // back: stores, sort engine, read walk, result register
    sibm_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_LAYERS   (MAX_LAYERS),
        .MAX_TEMPLATE (MAX_TEMPLATE)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .res   (res)
    );

endmodule

// ===== src/sibm_ram.sv =====
// ----------------------------------------------------------------------------
// sibm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sibm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/sibm_front.sv =====
// ----------------------------------------------------------------------------
// sibm_front
// Accepts command items, decodes the mode and queues them (two deep).
// ----------------------------------------------------------------------------
module sibm_front (
    input  logic             clk,
    input  logic             rst_n,
    sibm_cmd_if.sink         cmd,
    output sibm_pkg::qhead_t head,
    input  logic             pop
);
    import sibm_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    logic       take;
    item_t      incoming;

    assign cmd.ready = (fill_reg != 2'd2);
    assign push      = cmd.valid && cmd.ready;
    assign take      = pop && (fill_reg != 2'd0);

    always_comb
    begin
        incoming.op              = op_t'(cmd.mode);
        incoming.coord_x         = cmd.coord_x;
        incoming.coord_y         = cmd.coord_y;
        incoming.coord_z         = cmd.coord_z;
        incoming.layer_span      = cmd.layer_span;
        incoming.layer_entries   = cmd.layer_entries;
        incoming.template_offset = cmd.template_offset;
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !take)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (take && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (take)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= incoming;
        end
    end

    assign head.valid = (fill_reg != 2'd0);
    assign head.item  = slot_reg[rd_ptr_reg];

endmodule

// ===== src/sibm_back.sv =====
// ----------------------------------------------------------------------------
// sibm_back
// Sequencer: stores loads, sorts per axis by rank counting, walks the
// layer/template lists and drives the result register.
// ----------------------------------------------------------------------------
module sibm_back #(
    parameter int MAX_VERTICES = sibm_pkg::DEF_MAX_VERTICES,
    parameter int MAX_LAYERS   = sibm_pkg::DEF_MAX_LAYERS,
    parameter int MAX_TEMPLATE = sibm_pkg::DEF_MAX_TEMPLATE
) (
    input  logic             clk,
    input  logic             rst_n,
    input  sibm_pkg::qhead_t head,
    output logic             pop,
    sibm_res_if.source       res
);
    import sibm_pkg::*;

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int VCW = $clog2(MAX_VERTICES + 1);
    localparam int LAW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int LCW = $clog2(MAX_LAYERS + 1);
    localparam int TAW = (MAX_TEMPLATE > 1) ? $clog2(MAX_TEMPLATE) : 1;
    localparam int TCW = $clog2(MAX_TEMPLATE + 1);
    localparam int TPW = $clog2(MAX_LAYERS * ((1 << COUNT_W) - 1) + 1);
    localparam int BW  = $clog2(MAX_LAYERS * ((1 << SPAN_W) - 1) + 1);
    localparam int PW  = BW + 1;
    localparam int XW  = (PW > VCW) ? PW : VCW;
    localparam int LDW = SPAN_W + COUNT_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_NL   = 4'd1;
    localparam logic [3:0] S_NW   = 4'd2;
    localparam logic [3:0] S_SI   = 4'd3;
    localparam logic [3:0] S_SL   = 4'd4;
    localparam logic [3:0] S_SC   = 4'd5;
    localparam logic [3:0] S_SW   = 4'd6;
    localparam logic [3:0] S_TR   = 4'd7;
    localparam logic [3:0] S_TW   = 4'd8;
    localparam logic [3:0] S_PW   = 4'd9;
    localparam logic [3:0] S_EMIT = 4'd10;

    localparam logic [1:0] AXIS_END = 2'(AXES);

    logic [3:0]          state_reg,  state_next;
    logic                sorted_reg, sorted_next;
    logic                phase_reg,  phase_next;
    logic [1:0]          axis_reg,   axis_next;
    logic [LCW-1:0]      layer_reg,  layer_next;
    logic [COUNT_W-1:0]  entry_reg,  entry_next;
    logic [TPW-1:0]      tpos_reg,   tpos_next;
    logic [BW-1:0]       base_reg,   base_next;
    logic [VCW-1:0]      vtotal_reg, vtotal_next;
    logic [LCW-1:0]      ltotal_reg, ltotal_next;
    logic [TCW-1:0]      tfill_reg,  tfill_next;
    logic [VW-1:0]       i_reg,      i_next;
    logic [VW-1:0]       j_reg,      j_next;
    logic [VW-1:0]       cnt_reg,    cnt_next;
    logic [VERTEX_W-1:0] vi_reg,     vi_next;
    logic                err_reg,    err_next;
    logic [VW-1:0]       value_reg,  value_next;
    logic [1:0]          eaxis_reg,  eaxis_next;
    logic                elast_reg,  elast_next;
    logic                ovalid_reg, ovalid_next;
    logic [INDEX_W-1:0]  oindex_reg, oindex_next;
    logic [1:0]          oaxis_reg,  oaxis_next;
    logic                olast_reg,  olast_next;
    logic                oerr_reg,   oerr_next;

    // memory ports
    logic                v_we;
    logic [VW-1:0]       v_raddr;
    logic [VERTEX_W-1:0] v_rdata;
    logic                s_we;
    logic [VW-1:0]       s_raddr;
    logic [VW-1:0]       s_rdata;
    logic                l_we;
    logic [LDW-1:0]      l_rdata;
    logic                t_we;
    logic [OFFSET_W-1:0] t_rdata;

    logic [SPAN_W-1:0]   rd_span;
    logic [COUNT_W-1:0]  rd_count;
    logic [OFFSET_W-1:0] off;
    logic [PW-1:0]       pos;
    logic                pos_err;
    logic                prec;
    logic                out_free;
    item_t               it;

    assign it       = head.item;
    assign rd_span  = l_rdata[LDW-1:COUNT_W];
    assign rd_count = l_rdata[COUNT_W-1:0];
    assign out_free = !ovalid_reg || res.ready;

    assign off     = (32'(tpos_reg) < 32'(MAX_TEMPLATE)) ? t_rdata : '0;
    assign pos     = PW'(base_reg) + PW'(off);
    assign pos_err = XW'(pos) >= XW'(vtotal_reg);

    // vertex j goes ahead of vertex i: key first, original number breaks ties
    assign prec = {sort_key(axis_reg, v_rdata), j_reg} < {sort_key(axis_reg, vi_reg), i_reg};

    always_comb
    begin
        state_next  = state_reg;
        sorted_next = sorted_reg;
        phase_next  = phase_reg;
        axis_next   = axis_reg;
        layer_next  = layer_reg;
        entry_next  = entry_reg;
        tpos_next   = tpos_reg;
        base_next   = base_reg;
        vtotal_next = vtotal_reg;
        ltotal_next = ltotal_reg;
        tfill_next  = tfill_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        cnt_next    = cnt_reg;
        vi_next     = vi_reg;
        err_next    = err_reg;
        value_next  = value_reg;
        eaxis_next  = eaxis_reg;
        elast_next  = elast_reg;
        ovalid_next = ovalid_reg && !res.ready;
        oindex_next = oindex_reg;
        oaxis_next  = oaxis_reg;
        olast_next  = olast_reg;
        oerr_next   = oerr_reg;
        pop         = 1'b0;
        v_we        = 1'b0;
        s_we        = 1'b0;
        l_we        = 1'b0;
        t_we        = 1'b0;
        v_raddr     = i_reg;
        s_raddr     = VW'(pos);

        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (it.op == OP_READ)
                    begin
                        phase_next = 1'b0;
                        state_next = S_NL;
                    end
                    else
                    begin
                        // any load rewinds the read walk
                        sorted_next = 1'b0;
                        axis_next   = 2'd0;
                        layer_next  = '0;
                        entry_next  = '0;
                        tpos_next   = '0;
                        base_next   = '0;
                        unique case (it.op)
                            OP_VERTEX:
                            begin
                                if (32'(vtotal_reg) < 32'(MAX_VERTICES))
                                begin
                                    v_we        = 1'b1;
                                    vtotal_next = vtotal_reg + 1'b1;
                                end
                            end
                            OP_LAYER:
                            begin
                                if (32'(ltotal_reg) < 32'(MAX_LAYERS))
                                begin
                                    l_we        = 1'b1;
                                    ltotal_next = ltotal_reg + 1'b1;
                                end
                            end
                            default:
                            begin
                                if (32'(tfill_reg) < 32'(MAX_TEMPLATE))
                                begin
                                    t_we       = 1'b1;
                                    tfill_next = tfill_reg + 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end
            S_NL:
            begin
                if (axis_reg == AXIS_END)
                begin
                    elast_next = 1'b1;
                    state_next = phase_reg ? S_EMIT : S_IDLE;
                end
                else if (layer_reg < ltotal_reg)
                begin
                    state_next = S_NW;
                end
                else
                begin
                    axis_next   = axis_reg + 2'd1;
                    layer_next  = '0;
                    entry_next  = '0;
                    tpos_next   = '0;
                    base_next   = '0;
                    sorted_next = 1'b0;
                end
            end
            S_NW:
            begin
                if (entry_reg >= rd_count)
                begin
                    base_next  = base_reg + BW'(rd_span);
                    layer_next = layer_reg + 1'b1;
                    entry_next = '0;
                    state_next = S_NL;
                end
                else if (phase_reg)
                begin
                    elast_next = 1'b0;
                    state_next = S_EMIT;
                end
                else if (sorted_reg || vtotal_reg == '0)
                begin
                    sorted_next = 1'b1;
                    state_next  = S_TR;
                end
                else
                begin
                    i_next     = '0;
                    state_next = S_SI;
                end
            end
            S_SI:
            begin
                cnt_next   = '0;
                state_next = S_SL;
            end
            S_SL:
            begin
                vi_next    = v_rdata;
                v_raddr    = '0;
                j_next     = '0;
                state_next = S_SC;
            end
            S_SC:
            begin
                if (prec)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (VCW'(j_reg) == vtotal_reg - 1'b1)
                begin
                    state_next = S_SW;
                end
                else
                begin
                    v_raddr = j_reg + 1'b1;
                    j_next  = j_reg + 1'b1;
                end
            end
            S_SW:
            begin
                s_we = 1'b1;
                if (VCW'(i_reg) == vtotal_reg - 1'b1)
                begin
                    sorted_next = 1'b1;
                    state_next  = S_TR;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_SI;
                end
            end
            S_TR:
            begin
                state_next = S_TW;
            end
            S_TW:
            begin
                err_next   = pos_err;
                eaxis_next = axis_reg;
                state_next = S_PW;
            end
            S_PW:
            begin
                value_next = err_reg ? '0 : s_rdata;
                entry_next = entry_reg + 1'b1;
                tpos_next  = tpos_reg + 1'b1;
                phase_next = 1'b1;
                state_next = S_NL;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    oindex_next = INDEX_W'(value_reg);
                    oaxis_next  = eaxis_reg;
                    olast_next  = elast_reg;
                    oerr_next   = err_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            sorted_reg <= 1'b0;
            phase_reg  <= 1'b0;
            axis_reg   <= 2'd0;
            layer_reg  <= '0;
            entry_reg  <= '0;
            tpos_reg   <= '0;
            base_reg   <= '0;
            vtotal_reg <= '0;
            ltotal_reg <= '0;
            tfill_reg  <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sorted_reg <= sorted_next;
            phase_reg  <= phase_next;
            axis_reg   <= axis_next;
            layer_reg  <= layer_next;
            entry_reg  <= entry_next;
            tpos_reg   <= tpos_next;
            base_reg   <= base_next;
            vtotal_reg <= vtotal_next;
            ltotal_reg <= ltotal_next;
            tfill_reg  <= tfill_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vi_reg     <= vi_next;
        err_reg    <= err_next;
        value_reg  <= value_next;
        eaxis_reg  <= eaxis_next;
        elast_reg  <= elast_next;
        oindex_reg <= oindex_next;
        oaxis_reg  <= oaxis_next;
        olast_reg  <= olast_next;
        oerr_reg   <= oerr_next;
    end

    sibm_ram #(.WIDTH(VERTEX_W), .DEPTH(MAX_VERTICES)) u_vertex (
        .clk     (clk),
        .wr_en   (v_we),
        .wr_addr (VW'(vtotal_reg)),
        .wr_data ({it.coord_x, it.coord_y, it.coord_z}),
        .rd_addr (v_raddr),
        .rd_data (v_rdata)
    );

    sibm_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_order (
        .clk     (clk),
        .wr_en   (s_we),
        .wr_addr (cnt_reg),
        .wr_data (i_reg),
        .rd_addr (s_raddr),
        .rd_data (s_rdata)
    );

    sibm_ram #(.WIDTH(LDW), .DEPTH(MAX_LAYERS)) u_layer (
        .clk     (clk),
        .wr_en   (l_we),
        .wr_addr (LAW'(ltotal_reg)),
        .wr_data ({it.layer_span, it.layer_entries}),
        .rd_addr (LAW'(layer_reg)),
        .rd_data (l_rdata)
    );

    sibm_ram #(.WIDTH(OFFSET_W), .DEPTH(MAX_TEMPLATE)) u_template (
        .clk     (clk),
        .wr_en   (t_we),
        .wr_addr (TAW'(tfill_reg)),
        .wr_data (it.template_offset),
        .rd_addr (TAW'(tpos_reg)),
        .rd_data (t_rdata)
    );

    assign res.valid       = ovalid_reg;
    assign res.index_value = oindex_reg;
    assign res.view_axis   = oaxis_reg;
    assign res.last_index  = olast_reg;
    assign res.range_error = oerr_reg;

endmodule

// ===== src/sibm_checker.sv =====
// ----------------------------------------------------------------------------
// sibm_checker
// Port-level checks for the index map builder, bound to the top level.
// ----------------------------------------------------------------------------
module sibm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic [1:0] cmd_mode,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] res_index_value,
    input logic [1:0] res_view_axis,
    input logic       res_last_index,
    input logic       res_range_error
);
    import sibm_pkg::*;

    logic [15:0] pend_reg;
    logic        rd_acc;
    logic        res_acc;

    assign rd_acc  = cmd_valid && cmd_ready && (cmd_mode == OP_READ);
    assign res_acc = res_valid && res_ready;

    // reads outstanding that may still give a result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (pend_reg != 16'hFFFF)
        begin
            pend_reg <= pend_reg + 16'(rd_acc) - 16'(res_acc);
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_index_value)
            && $stable(res_view_axis) && $stable(res_last_index))
        else $error("result changed while stalled");

    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pend_reg != 16'd0)
        else $error("result without a read");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_range_error |-> res_index_value == 8'd0)
        else $error("out-of-range index not zero");

    a_last_axis: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_last_index |-> res_view_axis == 2'd2)
        else $error("final index not on the third axis");

endmodule

bind axis_sorted_index_map_builder_core sibm_checker u_sibm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .cmd_mode        (cmd.mode),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_index_value (res.index_value),
    .res_view_axis   (res.view_axis),
    .res_last_index  (res.last_index),
    .res_range_error (res.range_error)
);

// ===== bench/axis_sorted_index_map_builder_core_test.sv =====
// ----------------------------------------------------------------------------
// axis_sorted_index_map_builder_core_test
// Self-checking bench for the index map builder. It drives command items with
// random idling, mirrors the vertex, layer and template stores and the read
// walk, and checks every index item against the mirrored sorted order.
// ----------------------------------------------------------------------------
module axis_sorted_index_map_builder_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sibm_pkg::*;

    localparam int NV = DEF_MAX_VERTICES;
    localparam int NL = DEF_MAX_LAYERS;
    localparam int NT = DEF_MAX_TEMPLATE;
    // worst case: several full 256-vertex ranks plus many small ranks at full idling
    localparam longint CYCLE_LIMIT = 10_000_000;

    typedef struct packed {
        logic [7:0] idx;
        logic [1:0] axis;
        logic       last;
        logic       err;
    } index_res_t;

    // position of the read walk through axes, layers and template entries
    typedef struct {
        bit          started;
        bit          sorted;
        int unsigned axis;
        int unsigned layer;
        int unsigned entry;
        int unsigned tpos;
        int unsigned base;
    } walk_t;

    logic clk;
    logic rst_n;

    sibm_cmd_if cmd_ch ();
    sibm_res_if res_ch ();

    axis_sorted_index_map_builder_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch.sink),
        .res   (res_ch.source)
    );

    // --- mirrored state ------------------------------------------------------
    // coordinate order used as sort keys per axis: 0 x, 1 y, 2 z
    int unsigned key_seq [3][3] = '{'{0, 2, 1}, '{1, 0, 2}, '{2, 1, 0}};

    logic signed [15:0] vtx [NV][3];
    int unsigned rank_perm [NV];
    int unsigned vert_cnt;
    int unsigned layer_cnt;
    int unsigned tmpl_cnt;
    int unsigned span_mem [NL];
    int unsigned count_mem [NL];
    int unsigned tmpl_mem [NT];
    walk_t       walk;

    index_res_t index_due [$];

    // --- run bookkeeping ------------------------------------------------------
    bit          quiet;          // no idling on either side while set
    int unsigned items_sent;
    int unsigned n_fail;
    int unsigned n_checked;
    int unsigned n_range_err;
    int unsigned n_last;
    longint      cycles;

    // --- predictor ------------------------------------------------------------
    function automatic bit goes_first(input int unsigned ax, input int unsigned a,
                                      input int unsigned b);
        int unsigned c;
        for (int k = 0; k < 3; k++)
        begin
            c = key_seq[ax][k];
            if (vtx[a][c] < vtx[b][c])
                return 1'b1;
            if (vtx[a][c] > vtx[b][c])
                return 1'b0;
        end
        return a < b;   // ties keep original vertex order
    endfunction

    function automatic void rank_axis(input int unsigned ax);
        int unsigned v;
        int unsigned j;
        for (int unsigned i = 1; i < vert_cnt; i++)
        begin
            v = rank_perm[i];
            j = i;
            while (j > 0 && goes_first(ax, v, rank_perm[j-1]))
            begin
                rank_perm[j] = rank_perm[j-1];
                j--;
            end
            rank_perm[j] = v;
        end
    endfunction

    // step the walk to the next layer with an entry left, across axes
    function automatic void settle(ref walk_t w);
        while (w.axis < AXES)
        begin
            while (w.layer < layer_cnt && w.entry >= count_mem[w.layer])
            begin
                w.base  += span_mem[w.layer];
                w.layer++;
                w.entry  = 0;
            end
            if (w.layer < layer_cnt)
                return;
            w.axis++;
            w.layer  = 0;
            w.entry  = 0;
            w.tpos   = 0;
            w.base   = 0;
            w.sorted = 1'b0;
        end
    endfunction

    // a read must never land on a template entry that was never written
    function automatic bit read_safe();
        walk_t w;
        w = walk;
        settle(w);
        return w.axis >= AXES || w.tpos >= NT || w.tpos < tmpl_cnt;
    endfunction

    function automatic int unsigned total_entries();
        int unsigned s;
        s = 0;
        for (int unsigned i = 0; i < layer_cnt; i++)
            s += count_mem[i];
        return s;
    endfunction

    function automatic void track_item(input op_t op, input logic signed [15:0] x,
                                       input logic signed [15:0] y,
                                       input logic signed [15:0] z,
                                       input logic [8:0] sp, input logic [10:0] en,
                                       input logic [7:0] ofs);
        int unsigned off;
        int unsigned pos;
        bit          err;
        index_res_t  r;
        case (op)
            OP_VERTEX:
            begin
                if (vert_cnt < NV)
                begin
                    vtx[vert_cnt][0] = x;
                    vtx[vert_cnt][1] = y;
                    vtx[vert_cnt][2] = z;
                    vert_cnt++;
                end
                walk = '{default: 0};
            end
            OP_LAYER:
            begin
                if (layer_cnt < NL)
                begin
                    span_mem[layer_cnt]  = sp;
                    count_mem[layer_cnt] = en;
                    layer_cnt++;
                end
                walk = '{default: 0};
            end
            OP_TEMPLATE:
            begin
                if (tmpl_cnt < NT)
                begin
                    tmpl_mem[tmpl_cnt] = ofs;
                    tmpl_cnt++;
                end
                walk = '{default: 0};
            end
            default:
            begin
                if (!walk.started)
                begin
                    walk.started = 1'b1;
                    for (int unsigned i = 0; i < NV; i++)
                        rank_perm[i] = i;
                end
                settle(walk);
                if (walk.axis >= AXES)
                    return;     // exhausted or nothing to read
                if (!walk.sorted)
                begin
                    rank_axis(walk.axis);
                    walk.sorted = 1'b1;
                end
                if (walk.tpos < NT)
                    off = tmpl_mem[walk.tpos];
                else
                    off = 0;
                pos    = walk.base + off;
                err    = pos >= vert_cnt || pos >= NV;
                r.idx  = err ? 8'd0 : 8'(rank_perm[pos]);
                r.axis = 2'(walk.axis);
                r.err  = err;
                walk.entry++;
                walk.tpos++;
                settle(walk);
                r.last = walk.axis >= AXES;
                index_due.push_back(r);
            end
        endcase
    endfunction

    // --- clock and watchdog ---------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("axis_sorted_index_map_builder_core_test: done, errors");
            $finish;
        end
    end

    // --- result side: random stalls, one NBA per step ---------------------------
    initial
    begin
        int stall;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (res_ch.valid !== 1'b1);
            @(negedge clk);
        end
    end

    // --- checker --------------------------------------------------------------
    index_res_t seen_exp;

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            n_checked++;
            if (index_due.size() == 0)
            begin
                n_fail++;
                if (n_fail <= 10)
                    $display("%0t: index item with nothing expected (idx %0d axis %0d)",
                             $realtime, res_ch.index_value, res_ch.view_axis);
            end
            else
            begin
                seen_exp = index_due.pop_front();
                if (seen_exp.err)
                    n_range_err++;
                if (seen_exp.last)
                    n_last++;
                if (res_ch.index_value !== seen_exp.idx || res_ch.view_axis !== seen_exp.axis
                    || res_ch.last_index !== seen_exp.last
                    || res_ch.range_error !== seen_exp.err)
                begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display({"%0t: mismatch idx/axis/last/err expected %0d/%0d/%0b/%0b",
                                  " got %0d/%0d/%0b/%0b"}, $realtime, seen_exp.idx,
                                 seen_exp.axis, seen_exp.last, seen_exp.err,
                                 res_ch.index_value, res_ch.view_axis, res_ch.last_index,
                                 res_ch.range_error);
                end
            end
        end
    end

    // --- command side -----------------------------------------------------------
    // called and left at a falling edge; valid stays high between back-to-back items
    task automatic send_item(input op_t op, input logic signed [15:0] x,
                             input logic signed [15:0] y, input logic signed [15:0] z,
                             input logic [8:0] sp, input logic [10:0] en,
                             input logic [7:0] ofs);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.mode            <= op;
        cmd_ch.coord_x         <= x;
        cmd_ch.coord_y         <= y;
        cmd_ch.coord_z         <= z;
        cmd_ch.layer_span      <= sp;
        cmd_ch.layer_entries   <= en;
        cmd_ch.template_offset <= ofs;
        cmd_ch.valid           <= 1'b1;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        track_item(op, x, y, z, sp, en, ofs);
        items_sent++;
        @(negedge clk);
    endtask

    // unused fields carry random junk
    task automatic send_vertex(input logic signed [15:0] x, input logic signed [15:0] y,
                               input logic signed [15:0] z);
        send_item(OP_VERTEX, x, y, z, 9'($urandom), 11'($urandom), 8'($urandom));
    endtask

    task automatic send_layer(input logic [8:0] sp, input logic [10:0] en);
        send_item(OP_LAYER, 16'($urandom), 16'($urandom), 16'($urandom), sp, en,
                  8'($urandom));
    endtask

    task automatic send_tmpl(input logic [7:0] ofs);
        send_item(OP_TEMPLATE, 16'($urandom), 16'($urandom), 16'($urandom),
                  9'($urandom), 11'($urandom), ofs);
    endtask

    task automatic send_read();
        send_item(OP_READ, 16'($urandom), 16'($urandom), 16'($urandom), 9'($urandom),
                  11'($urandom), 8'($urandom));
    endtask

    // hold the sender back until every index item has come
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (index_due.size() != 0);
    endtask

    function automatic logic signed [15:0] pick_coord();
        // narrow set half the time so equal keys and ties turn up
        case ($urandom_range(0, 9))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2:       return -16'sd1;
            3:       return 16'sd0;
            4:       return 16'sd1;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_offset();
        int unsigned hi;
        hi = (vert_cnt + 2 > 255) ? 255 : vert_cnt + 2;
        if ($urandom_range(0, 9) < 7)
            return 8'($urandom_range(0, hi));
        return 8'($urandom_range(0, 255));
    endfunction

    // --- tests ----------------------------------------------------------------
    // reads with nothing to walk: no vertices, then vertices but no layers
    task automatic test_empty_reads();
        send_read();
        send_read();
        send_vertex(16'sd256, -16'sd256, 16'sd0);
        send_vertex(16'sd0, 16'sd0, 16'sd0);
        send_read();
    endtask

    // coordinate extremes, partly equal vertices, an empty layer, an out-of-range
    // offset, the full walk of all three axes and one read past the end
    task automatic test_directed_walk();
        send_vertex(16'sd32767, -16'sd32768, 16'sd0);
        send_vertex(-16'sd32768, 16'sd32767, -16'sd1);
        send_vertex(16'sd0, 16'sd0, 16'sd0);     // shares x and y with vertex 4, z decides
        send_vertex(-16'sd1, -16'sd1, -16'sd1);
        send_vertex(16'sd0, 16'sd0, 16'sd1);
        send_layer(9'd3, 11'd2);
        send_layer(9'd0, 11'd0);                 // empty layer
        send_layer(9'd4, 11'd3);
        send_tmpl(8'd0);
        send_tmpl(8'd2);
        send_tmpl(8'd0);
        send_tmpl(8'd3);
        send_tmpl(8'd255);                       // past the loaded vertices
        repeat (16) send_read();
    endtask

    // bursts of loads followed by read runs of random length; a load inside a
    // run rewinds the walk and forces a fresh sort
    task automatic test_random_bursts(input int unsigned n_items);
        int unsigned stop_at;
        int unsigned nloads;
        int unsigned nreads;
        int unsigned pick;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            quiet  = ($urandom_range(0, 7) == 0);
            nloads = $urandom_range(0, 3);
            repeat (nloads)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 30 && vert_cnt < 24)
                    send_vertex(pick_coord(), pick_coord(), pick_coord());
                else if (pick < 50 && layer_cnt < NL - 1)
                    send_layer(($urandom_range(0, 4) == 0) ? 9'($urandom_range(0, 256))
                                                          : 9'($urandom_range(0, 4)),
                               11'($urandom_range(0, 6)));
                else
                    send_tmpl(pick_offset());
            end
            nreads = $urandom_range(1, 3 * total_entries() + 3);
            if (nreads > 150)
                nreads = 150;
            repeat (nreads)
            begin
                if (read_safe())
                    send_read();
                else
                    send_tmpl(pick_offset());
            end
            if ($urandom_range(0, 19) == 0)
                drain();
        end
        quiet = 1'b0;
    endtask

    // full layer store with one ignored descriptor, then a short read run
    task automatic test_layer_store_full();
        int unsigned rd;
        drain();
        while (layer_cnt < NL - 1)
            send_layer(9'($urandom_range(0, 4)), 11'd0);
        send_layer(9'd256, 11'd4);
        send_layer(9'd255, 11'd1023);            // store full, ignored
        repeat (4) send_tmpl(pick_offset());
        rd = 0;
        while (rd < 24)
        begin
            quiet = (rd >= 12);
            if (read_safe())
                send_read();
            rd++;
        end
        quiet = 1'b0;
        drain();
    endtask

    // vertex store full, then a few reads over the largest rank
    task automatic test_vertex_store_full();
        while (vert_cnt < NV)
            send_vertex(16'($urandom), 16'($urandom), 16'($urandom));
        send_vertex(16'($urandom), 16'($urandom), 16'($urandom));   // ignored
        repeat (3)
        begin
            if (read_safe())
                send_read();
        end
    endtask

    // --- main sequence --------------------------------------------------------
    initial
    begin
        rst_n                  = 1'b0;
        cmd_ch.valid           = 1'b0;
        cmd_ch.mode            = OP_VERTEX;
        cmd_ch.coord_x         = '0;
        cmd_ch.coord_y         = '0;
        cmd_ch.coord_z         = '0;
        cmd_ch.layer_span      = '0;
        cmd_ch.layer_entries   = '0;
        cmd_ch.template_offset = '0;
        quiet      = 1'b0;
        items_sent = 0;
        n_fail     = 0;
        n_checked  = 0;
        n_range_err = 0;
        n_last     = 0;
        cycles     = 0;
        vert_cnt   = 0;
        layer_cnt  = 0;
        tmpl_cnt   = 0;
        walk       = '{default: 0};
        for (int unsigned i = 0; i < NV; i++)
            rank_perm[i] = i;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_reads();
        test_directed_walk();
        test_random_bursts(720);
        test_layer_store_full();
        test_vertex_store_full();

        drain();
        repeat (200) @(posedge clk);

        $display("covered %0d command items, %0d index items checked (%0d range errors,",
                 items_sent, n_checked, n_range_err);
        $display("  %0d completed walks, full layer and vertex stores)", n_last);
        if (n_fail == 0)
            $display("axis_sorted_index_map_builder_core_test: done, clean");
        else
        begin
            $display("%0d failures", n_fail);
            $display("axis_sorted_index_map_builder_core_test: done, errors");
        end
        $finish;
    end

endmodule

// ===== axis_sorted_index_map_builder_core.f =====
src/sibm_pkg.sv
src/sibm_if.sv
src/sibm_ram.sv
src/sibm_front.sv
src/sibm_back.sv
src/axis_sorted_index_map_builder_core.sv
src/sibm_checker.sv
bench/axis_sorted_index_map_builder_core_test.sv
